>>> design/ata_pkg.sv
// ============================================================================
// ata_pkg
// Shared constants and the CORDIC arctangent table for the tilt block.
// ============================================================================
`default_nettype none

package ata_pkg;

    localparam int SampleWidthDefault  = 20;
    localparam int CordicStagesDefault = 16;
    localparam int GuardBits           = 12;
    localparam int TableLen            = 24;
    localparam int AngleWidth          = 16;
    localparam int AccWidth            = 24;
    localparam logic [AngleWidth-1:0] Angle90  = 16'd23040;
    localparam logic [AngleWidth-1:0] Angle180 = 16'd46080;

    function automatic logic [AccWidth-1:0] atan_entry(input logic [4:0] idx);
        logic [AccWidth-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = 24'd2949120;
                5'd1:    v = 24'd1740967;
                5'd2:    v = 24'd919879;
                5'd3:    v = 24'd466945;
                5'd4:    v = 24'd234379;
                5'd5:    v = 24'd117304;
                5'd6:    v = 24'd58666;
                5'd7:    v = 24'd29335;
                5'd8:    v = 24'd14668;
                5'd9:    v = 24'd7334;
                5'd10:   v = 24'd3667;
                5'd11:   v = 24'd1833;
                5'd12:   v = 24'd917;
                5'd13:   v = 24'd458;
                5'd14:   v = 24'd229;
                5'd15:   v = 24'd115;
                5'd16:   v = 24'd57;
                5'd17:   v = 24'd29;
                5'd18:   v = 24'd14;
                5'd19:   v = 24'd7;
                5'd20:   v = 24'd4;
                5'd21:   v = 24'd2;
                5'd22:   v = 24'd1;
                default: v = 24'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

>>> design/ata_stream_if.sv
// ============================================================================
// ata_stream_if
// Valid/ready channel carrying a generic payload.
// ============================================================================
`default_nettype none

interface ata_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/accel_tilt_angles.sv
// ============================================================================
// accel_tilt_angles
// Vector magnitude and three tilt angles of one accelerometer sample.
// ============================================================================
// Channel   Dir  Payload
// in_ch     in   accel_x, accel_y, accel_z   (signed SAMPLE_WIDTH each)
// out_ch    out  magnitude, tilt_x, tilt_y, tilt_z
//
// Fully pipelined: one item per cycle while the output is not stalled. Stages:
// squares, sums, SW+1 root stages of one result bit each, CORDIC setup, the
// CORDIC stages, final rounding. Four square roots and three CORDIC units run
// side by side.
// rst_n clears the valid bits only. A stall at the output freezes the whole
// pipe; nothing is lost or repeated.
`default_nettype none

module accel_tilt_angles #(
    parameter int SAMPLE_WIDTH  = ata_pkg::SampleWidthDefault,
    parameter int CORDIC_STAGES = ata_pkg::CordicStagesDefault
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ata_stream_if.sink   in_ch,
    ata_stream_if.source out_ch
);
    import ata_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int SQW  = 2 * SW + 2;          // sum of three squares
    localparam int RW   = SW + 1;              // root width
    localparam int NST  = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
    localparam int CW   = RW + GuardBits + 3;  // CORDIC datapath width
    localparam int ACW  = AccWidth + 2;
    localparam int NSQ  = SW + 1;              // root iterations (2 bits each)
    localparam int DEPTH = 2 + NSQ + NST + 2;

    typedef logic [SQW-1:0] sq_t;

    // ------------------------------------------------------------------ pipe
    logic advance;
    logic [DEPTH-1:0] vld_reg;
    assign advance     = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = advance;
    assign out_ch.valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[DEPTH-2:0], in_ch.valid};
    end

    // stage 0: squares
    logic signed [SW-1:0] ax_s0_reg, ay_s0_reg, az_s0_reg;
    logic [2*SW-1:0] x2_reg, y2_reg, z2_reg;
    logic signed [SW-1:0] ix, iy, iz;
    logic signed [2*SW-1:0] ix2, iy2, iz2;
    assign ix = in_ch.data.accel_x;
    assign iy = in_ch.data.accel_y;
    assign iz = in_ch.data.accel_z;
    assign ix2 = ix * ix;
    assign iy2 = iy * iy;
    assign iz2 = iz * iz;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax_s0_reg <= ix;
            ay_s0_reg <= iy;
            az_s0_reg <= iz;
            x2_reg <= unsigned'(ix2);
            y2_reg <= unsigned'(iy2);
            z2_reg <= unsigned'(iz2);
        end
    end

    // root pipeline: digit-by-digit, one result bit per stage
    sq_t rem_reg [NSQ+1][4];
    logic [RW-1:0] root_reg [NSQ+1][4];
    logic signed [SW-1:0] sx_reg [NSQ+1], sy_reg [NSQ+1], sz_reg [NSQ+1];

    // stage 1: sums
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sx_reg[0] <= ax_s0_reg;
            sy_reg[0] <= ay_s0_reg;
            sz_reg[0] <= az_s0_reg;
            rem_reg[0][0] <= SQW'(x2_reg) + SQW'(y2_reg) + SQW'(z2_reg);
            rem_reg[0][1] <= SQW'(y2_reg) + SQW'(z2_reg);
            rem_reg[0][2] <= SQW'(x2_reg) + SQW'(z2_reg);
            rem_reg[0][3] <= SQW'(x2_reg) + SQW'(y2_reg);
            for (int k = 0; k < 4; k++)
                root_reg[0][k] <= '0;
        end
    end

    for (genvar s = 0; s < NSQ; s++) begin : g_sqrt
        localparam int SH = 2 * (NSQ - 1 - s);
        for (genvar k = 0; k < 4; k++) begin : g_lane
            logic [SQW+1:0] trial;
            logic [SQW+1:0] top;
            assign top   = (SQW+2)'(rem_reg[s][k] >> SH);
            assign trial = (SQW+2)'({root_reg[s][k], 2'b01});
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    if (top >= trial)
                    begin
                        rem_reg[s+1][k]  <= rem_reg[s][k] - SQW'(trial << SH);
                        root_reg[s+1][k] <= {root_reg[s][k][RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s+1][k]  <= rem_reg[s][k];
                        root_reg[s+1][k] <= {root_reg[s][k][RW-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                sx_reg[s+1] <= sx_reg[s];
                sy_reg[s+1] <= sy_reg[s];
                sz_reg[s+1] <= sz_reg[s];
            end
        end
    end

    // CORDIC setup: lane 0 = x tilt, 1 = y tilt, 2 = z tilt
    logic signed [SW-1:0] fx, fy, fz;
    logic [RW-1:0] rmag, ryz, rxz, rxy;
    assign fx = sx_reg[NSQ];
    assign fy = sy_reg[NSQ];
    assign fz = sz_reg[NSQ];
    assign rmag = root_reg[NSQ][0];
    assign ryz  = root_reg[NSQ][1];
    assign rxz  = root_reg[NSQ][2];
    assign rxy  = root_reg[NSQ][3];

    logic [RW:0] num_in [3], den_in [3];
    logic        neg_in [3];
    always_comb
    begin
        num_in[0] = fx[SW-1] ? (RW+1)'(-(RW+1)'(signed'(fx))) : (RW+1)'(fx);
        num_in[1] = fy[SW-1] ? (RW+1)'(-(RW+1)'(signed'(fy))) : (RW+1)'(fy);
        num_in[2] = (RW+1)'(rxy);
        den_in[0] = (RW+1)'(ryz);
        den_in[1] = (RW+1)'(rxz);
        den_in[2] = fz[SW-1] ? (RW+1)'(-(RW+1)'(signed'(fz))) : (RW+1)'(fz);
        neg_in[0] = fx[SW-1];
        neg_in[1] = fy[SW-1];
        neg_in[2] = fz[SW-1];
    end

    logic signed [CW-1:0]  cx_reg [NST+1][3], cy_reg [NST+1][3];
    logic signed [ACW-1:0] cz_reg [NST+1][3];
    logic                  neg_reg [NST+1][3], zero_reg [NST+1][3];
    logic [SW-1:0]         mag_reg [NST+1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cx_reg[0][k]   <= CW'(den_in[k]) <<< GuardBits;
                cy_reg[0][k]   <= CW'(num_in[k]) <<< GuardBits;
                cz_reg[0][k]   <= '0;
                neg_reg[0][k]  <= neg_in[k];
                zero_reg[0][k] <= (num_in[k] == '0);
            end
            mag_reg[0] <= (rmag[RW-1]) ? '1 : rmag[SW-1:0];
        end
    end

    for (genvar i = 0; i < NST; i++) begin : g_cordic
        localparam logic signed [ACW-1:0] TA = ACW'(atan_entry(5'(i)));
        for (genvar k = 0; k < 3; k++) begin : g_lane
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    if (!cy_reg[i][k][CW-1])
                    begin
                        cx_reg[i+1][k] <= cx_reg[i][k] + (cy_reg[i][k] >>> i);
                        cy_reg[i+1][k] <= cy_reg[i][k] - (cx_reg[i][k] >>> i);
                        cz_reg[i+1][k] <= cz_reg[i][k] + TA;
                    end
                    else
                    begin
                        cx_reg[i+1][k] <= cx_reg[i][k] - (cy_reg[i][k] >>> i);
                        cy_reg[i+1][k] <= cy_reg[i][k] + (cx_reg[i][k] >>> i);
                        cz_reg[i+1][k] <= cz_reg[i][k] - TA;
                    end
                    neg_reg[i+1][k]  <= neg_reg[i][k];
                    zero_reg[i+1][k] <= zero_reg[i][k];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (advance)
                mag_reg[i+1] <= mag_reg[i];
        end
    end

    // round, cap and fold
    logic [AngleWidth-1:0] ang [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [ACW-1:0] t;
            logic [ACW-1:0] r;
            t = cz_reg[NST][k];
            r = (t[ACW-1]) ? '0 : ((unsigned'(t) + ACW'(128)) >> 8);
            if (zero_reg[NST][k])
                ang[k] = '0;
            else if (r > ACW'(Angle90))
                ang[k] = Angle90;
            else
                ang[k] = AngleWidth'(r);
        end
    end

    logic [SW-1:0]         mag_out_reg;
    logic [AngleWidth-1:0] tx_reg, ty_reg, tz_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_out_reg <= mag_reg[NST];
            tx_reg <= neg_reg[NST][0] ? -ang[0] : ang[0];
            ty_reg <= neg_reg[NST][1] ? -ang[1] : ang[1];
            tz_reg <= neg_reg[NST][2] ? Angle180 - ang[2] : ang[2];
        end
    end

    assign out_ch.data.magnitude = mag_out_reg;
    assign out_ch.data.tilt_x    = tx_reg;
    assign out_ch.data.tilt_y    = ty_reg;
    assign out_ch.data.tilt_z    = tz_reg;

endmodule

`default_nettype wire

>>> design/ata_checker.sv
// ============================================================================
// ata_checker
// Port-level checks for the tilt block.
// ============================================================================
`default_nettype none

module ata_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [15:0] tilt_x,
    input wire logic [15:0] tilt_z
);
    import ata_pkg::*;

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready) else $error("ready while stalled");
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("not ready when empty");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_tz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tilt_z <= Angle180)) else $error("tilt_z out of range");
    a_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(tilt_x) <= $signed(Angle90) &&
                       $signed(tilt_x) >= -$signed({1'b0, Angle90})))
        else $error("tilt_x out of range");
endmodule

bind accel_tilt_angles ata_checker u_ata_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .tilt_x(out_ch.data.tilt_x), .tilt_z(out_ch.data.tilt_z)
);

`default_nettype wire
